@@ rtl/core/elg_pkg.sv @@
// elg_pkg: shared types and constants for the ElGamal engine.
// No dependencies.
package elg_pkg;

  localparam int ModWidth = 32;
  localparam int IoWidth  = 32;

  localparam logic [1:0] RegModulus    = 2'd0;
  localparam logic [1:0] RegGenerator  = 2'd1;
  localparam logic [1:0] RegPrivateKey = 2'd2;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,     // latch inputs, start reducing operands
    OP_REDUCE,   // one shift-subtract step of operand reduction
    OP_POW_H,    // exponent: h = g^x
    OP_POW_C1,   // exponent: c1 = g^k
    OP_POW_HK,   // exponent: t = h^k
    OP_POW_S,    // exponent: s = c1^x
    OP_MUL_C2,   // c2 = msg * t
    OP_INV,      // s inverse
    OP_MUL_M,    // m = c2 * inv
    OP_ZERO      // p below two
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_POW_H,
    ST_POW_C1,
    ST_POW_HK,
    ST_MUL_C2,
    ST_POW_S,
    ST_INV,
    ST_MUL_M,
    ST_OUT
  } state_t;

  typedef struct packed {
    op_t  op;
    logic start;   // first cycle of op
  } cmd_t;

  typedef struct packed {
    logic done;     // current op finished
    logic p_small;  // modulus below two
    logic func;     // latched operation
  } stat_t;

endpackage

@@ rtl/core/elgamal_modexp_engine.sv @@
// elgamal_modexp_engine: top level, config registers and stream ports.
// Depends on elg_pkg, elg_ctrl, elg_datapath.
//
// Textbook ElGamal over Z_p, one item at a time. An item is loaded, then goes
// through operand reduction and then a sequence of square-and-multiply
// exponentiations whose modular products run one multiplier bit a cycle in a
// shared add-double multiplier: three exponents on encrypt, two plus an
// extended Euclid pass (bit-serial divide and one product per step) on
// decrypt. The result holds on m_axis until taken; s_axis_tready is high
// only while the engine is idle.
module elgamal_modexp_engine #(
  parameter int MOD_WIDTH = elg_pkg::ModWidth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: message[31:0], session_key[63:32], cipher_first[95:64],
  //        cipher_second[127:96]
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tuser,     // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: first_value[31:0], second_value[63:32], public_value[95:64]
  output logic [95:0]  m_axis_tdata
);
  localparam int W = MOD_WIDTH;

  logic [31:0] modulus, generator, private_key;
  assign cfg_ready = 1'b1;

  // config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= 32'd3; generator <= 32'd2; private_key <= 32'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        elg_pkg::RegModulus:    modulus     <= cfg_data;
        elg_pkg::RegGenerator:  generator   <= cfg_data;
        elg_pkg::RegPrivateKey: private_key <= cfg_data;
        default: ;
      endcase
    end
  end

  // widen or trim a 32-bit value to W bits
  function automatic logic [W-1:0] fit(logic [31:0] v);
    logic [63:0] e;
    e = {32'd0, v};
    fit = e[W-1:0];
  endfunction
  function automatic logic [31:0] back(logic [W-1:0] v);
    logic [63+W:0] e;
    e = {64'd0, v};
    back = e[31:0];
  endfunction

  elg_pkg::cmd_t  cmd;
  elg_pkg::stat_t stat;
  logic [W-1:0] first, second, pub;
  logic in_fire, out_fire;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  elg_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_fire,
    .in_ready(s_axis_tready), .out_valid(m_axis_tvalid), .cmd, .stat
  );

  elg_datapath #(.MOD_WIDTH(W)) u_dp (
    .clk, .rst, .cmd, .stat,
    .p_in(fit(modulus)), .g_in(fit(generator)), .x_in(fit(private_key)),
    .func_in(s_axis_tuser),
    .a_in(s_axis_tuser ? fit(s_axis_tdata[95:64]) : fit(s_axis_tdata[31:0])),
    .b_in(s_axis_tuser ? fit(s_axis_tdata[127:96]) : fit(s_axis_tdata[63:32])),
    .first, .second, .pub
  );

  assign m_axis_tdata = {back(pub), back(second), back(first)};
endmodule

@@ rtl/core/elg_datapath.sv @@
// elg_datapath: iterative modular arithmetic for the ElGamal engine.
// Depends on elg_pkg. Bit-serial add-double multiply, square-multiply
// exponent, shift-subtract reduction and a bit-serial divide for Euclid.
module elg_datapath #(
  parameter int MOD_WIDTH = elg_pkg::ModWidth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  elg_pkg::cmd_t        cmd,
  output elg_pkg::stat_t       stat,
  input  logic [MOD_WIDTH-1:0] p_in,
  input  logic [MOD_WIDTH-1:0] g_in,
  input  logic [MOD_WIDTH-1:0] x_in,
  input  logic                 func_in,
  input  logic [MOD_WIDTH-1:0] a_in,   // msg or c1
  input  logic [MOD_WIDTH-1:0] b_in,   // k or c2
  output logic [MOD_WIDTH-1:0] first,
  output logic [MOD_WIDTH-1:0] second,
  output logic [MOD_WIDTH-1:0] pub
);
  localparam int W  = MOD_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] p, g, x, k, msg, c1, c2, h, t, s, iv, rf, rs;
  logic         func;
  logic [CW-1:0] rcnt;
  logic [1:0]    rsel;

  // ---- modular add helper (a,b < m)
  function automatic logic [W-1:0] add_mod(logic [W-1:0] a, logic [W-1:0] b,
                                           logic [W-1:0] m);
    logic [W-1:0] room;
    room = m - b;
    add_mod = (a >= room) ? (a - room) : (a + b);
  endfunction

  // ---- bit-serial multiplier state
  logic [W-1:0] ma, mb, macc;
  logic         mbusy;
  // ---- exponent state
  logic [W-1:0] eb, ee, eacc;
  logic         esq;      // 0: multiply acc, 1: square base
  logic         ebusy;
  // ---- reduction: rem of value mod p by shift-subtract, one bit a cycle
  logic [W:0]   rr;
  logic [W-1:0] rv;
  // ---- inverse state
  logic [W-1:0] r0, r1, t0, t1, q, dr;
  logic [CW-1:0] dcnt;
  logic [1:0]   iph;      // 0 divide, 1 multiply, 2 update
  logic         idone;

  logic [W:0] rr_sh;
  logic [W:0] dr_sh;
  logic [W-1:0] prod_neg;

  always_comb begin
    rr_sh = {rr[W-1:0], rv[W-1]};
    dr_sh = {dr, q[W-1]};
    prod_neg = (macc == '0) ? '0 : (p - macc);
  end

  logic done;
  assign stat.done    = done;
  assign stat.p_small = (p < W'(2));
  assign stat.func    = func;

  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      mbusy <= 1'b0;
      ebusy <= 1'b0;
      func  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (cmd.op)
        elg_pkg::OP_LOAD: begin
          p <= p_in; g <= g_in; x <= x_in; func <= func_in;
          msg <= a_in; c1 <= a_in; k <= b_in; c2 <= b_in;
          rsel <= 2'd0; rcnt <= '0; rr <= '0; rv <= g_in;
        end
        // reduce g, a, b mod p in turn: W bit steps each
        elg_pkg::OP_REDUCE: begin
          if (rcnt == CW'(W)) begin
            case (rsel)
              2'd0: begin g <= rr[W-1:0]; rv <= msg; end
              2'd1: begin msg <= rr[W-1:0]; c1 <= rr[W-1:0]; rv <= c2; end
              default: begin c2 <= rr[W-1:0]; end
            endcase
            rr <= '0; rcnt <= '0;
            if (rsel == 2'd2) done <= 1'b1;
            rsel <= rsel + 2'd1;
          end else begin
            rr <= (rr_sh >= {1'b0, p}) ? (rr_sh - {1'b0, p}) : rr_sh;
            rv <= {rv[W-2:0], 1'b0};
            rcnt <= rcnt + CW'(1);
          end
        end
        elg_pkg::OP_POW_H, elg_pkg::OP_POW_C1, elg_pkg::OP_POW_HK,
        elg_pkg::OP_POW_S: begin
          if (cmd.start) begin
            case (cmd.op)
              elg_pkg::OP_POW_H:  begin eb <= g;  ee <= x; end
              elg_pkg::OP_POW_C1: begin eb <= g;  ee <= k; end
              elg_pkg::OP_POW_HK: begin eb <= h;  ee <= k; end
              default:            begin eb <= c1; ee <= x; end
            endcase
            eacc <= W'(1); esq <= 1'b0; ebusy <= 1'b1; mbusy <= 1'b0;
          end else if (ebusy && !mbusy) begin
            if (ee == '0) begin
              ebusy <= 1'b0; done <= 1'b1;
              case (cmd.op)
                elg_pkg::OP_POW_H:  h <= eacc;
                elg_pkg::OP_POW_C1: rf <= eacc;
                elg_pkg::OP_POW_HK: t <= eacc;
                default:            s <= eacc;
              endcase
            end else if (!esq && !ee[0]) begin
              esq <= 1'b1;
            end else begin
              ma <= esq ? eb : eacc; mb <= eb; macc <= '0; mbusy <= 1'b1;
            end
          end else if (mbusy) begin
            if (mb == '0) begin
              mbusy <= 1'b0;
              if (esq) begin eb <= macc; ee <= ee >> 1; esq <= 1'b0; end
              else begin eacc <= macc; esq <= 1'b1; end
            end else begin
              if (mb[0]) macc <= add_mod(macc, ma, p);
              ma <= add_mod(ma, ma, p);
              mb <= mb >> 1;
            end
          end
        end
        elg_pkg::OP_MUL_C2, elg_pkg::OP_MUL_M: begin
          if (cmd.start) begin
            ma <= (cmd.op == elg_pkg::OP_MUL_C2) ? msg : c2;
            mb <= (cmd.op == elg_pkg::OP_MUL_C2) ? t : iv;
            macc <= '0; mbusy <= 1'b1;
          end else if (mbusy) begin
            if (mb == '0) begin
              mbusy <= 1'b0; done <= 1'b1;
              if (cmd.op == elg_pkg::OP_MUL_C2) rs <= macc;
              else begin rf <= macc; rs <= '0; end
            end else begin
              if (mb[0]) macc <= add_mod(macc, ma, p);
              ma <= add_mod(ma, ma, p);
              mb <= mb >> 1;
            end
          end
        end
        // extended Euclid: bit-serial divide, then q*t1 mod p, then update
        elg_pkg::OP_INV: begin
          if (cmd.start) begin
            r0 <= p; r1 <= s; t0 <= '0; t1 <= W'(1);
            q <= p; dr <= '0; dcnt <= '0; iph <= 2'd0;
            if (s == '0) begin iv <= W'(1); done <= 1'b1; end
            idone <= (s == '0);
          end else if (!idone) begin
            case (iph)
              2'd0: begin
                if (r1 == '0) begin
                  iv <= (r0 == W'(1)) ? t0 : '0; done <= 1'b1; idone <= 1'b1;
                end else if (dcnt == CW'(W)) begin
                  // q holds quotient, dr remainder; q equals p only when r1 is 1
                  ma <= t1; mb <= (q >= p) ? (q - p) : q; macc <= '0;
                  iph <= 2'd1;
                end else begin
                  if (dr_sh >= {1'b0, r1}) begin
                    dr <= W'(dr_sh - {1'b0, r1}); q <= {q[W-2:0], 1'b1};
                  end else begin
                    dr <= dr_sh[W-1:0]; q <= {q[W-2:0], 1'b0};
                  end
                  dcnt <= dcnt + CW'(1);
                end
              end
              2'd1: begin
                if (mb == '0) iph <= 2'd2;
                else begin
                  if (mb[0]) macc <= add_mod(macc, ma, p);
                  ma <= add_mod(ma, ma, p);
                  mb <= mb >> 1;
                end
              end
              default: begin
                t0 <= t1; t1 <= add_mod(t0, prod_neg, p);
                r0 <= r1; r1 <= dr;
                q <= r1; dr <= '0; dcnt <= '0; iph <= 2'd0;
              end
            endcase
          end
        end
        elg_pkg::OP_ZERO: begin
          rf <= '0; rs <= '0; h <= '0; done <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // POW_C1 writes rf; encrypt leaves it; decrypt MUL_M overwrites it
  assign first  = rf;
  assign second = (func && !stat.p_small) ? '0 : rs;
  assign pub    = h;

  // The dividend register reloads with the old divisor
  a_div: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == elg_pkg::OP_INV && !cmd.start && !idone && iph == 2'd2) |=> (q == $past(r1)))
    else $error("divide reload wrong");
  a_loadquiet: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == elg_pkg::OP_LOAD) |=> !done)
    else $error("done raised by load");
  a_rem: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == elg_pkg::OP_REDUCE && rcnt != '0) |-> (rr[W-1:0] < p || p == '0))
    else $error("reduction overflow");
endmodule

@@ rtl/core/elg_ctrl.sv @@
// elg_ctrl: sequencer for the ElGamal engine.
// Depends on elg_pkg; drives elg_datapath through cmd_t/stat_t.
module elg_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic           out_fire,
  output logic           in_ready,
  output logic           out_valid,
  output elg_pkg::cmd_t  cmd,
  input  elg_pkg::stat_t stat
);
  elg_pkg::state_t state, state_next;
  logic started, started_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= elg_pkg::ST_IDLE; started <= 1'b0;
    end else begin
      state <= state_next; started <= started_next;
    end
  end

  always_comb begin
    state_next   = state;
    started_next = 1'b1;
    cmd.op       = elg_pkg::OP_NONE;
    cmd.start    = !started;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    case (state)
      elg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        started_next = 1'b0;
        if (in_fire) begin
          cmd.op = elg_pkg::OP_LOAD;
          state_next = elg_pkg::ST_REDUCE;
        end
      end
      elg_pkg::ST_REDUCE: begin
        if (stat.p_small) begin
          cmd.op = elg_pkg::OP_ZERO;
          if (stat.done) begin state_next = elg_pkg::ST_OUT; started_next = 1'b0; end
        end else begin
          cmd.op = elg_pkg::OP_REDUCE;
          if (stat.done) begin state_next = elg_pkg::ST_POW_H; started_next = 1'b0; end
        end
      end
      elg_pkg::ST_POW_H: begin
        cmd.op = elg_pkg::OP_POW_H;
        if (stat.done) begin
          state_next = stat.func ? elg_pkg::ST_POW_S : elg_pkg::ST_POW_C1;
          started_next = 1'b0;
        end
      end
      elg_pkg::ST_POW_C1: begin
        cmd.op = elg_pkg::OP_POW_C1;
        if (stat.done) begin state_next = elg_pkg::ST_POW_HK; started_next = 1'b0; end
      end
      elg_pkg::ST_POW_HK: begin
        cmd.op = elg_pkg::OP_POW_HK;
        if (stat.done) begin state_next = elg_pkg::ST_MUL_C2; started_next = 1'b0; end
      end
      elg_pkg::ST_MUL_C2: begin
        cmd.op = elg_pkg::OP_MUL_C2;
        if (stat.done) begin state_next = elg_pkg::ST_OUT; started_next = 1'b0; end
      end
      elg_pkg::ST_POW_S: begin
        cmd.op = elg_pkg::OP_POW_S;
        if (stat.done) begin state_next = elg_pkg::ST_INV; started_next = 1'b0; end
      end
      elg_pkg::ST_INV: begin
        cmd.op = elg_pkg::OP_INV;
        if (stat.done) begin state_next = elg_pkg::ST_MUL_M; started_next = 1'b0; end
      end
      elg_pkg::ST_MUL_M: begin
        cmd.op = elg_pkg::OP_MUL_M;
        if (stat.done) begin state_next = elg_pkg::ST_OUT; started_next = 1'b0; end
      end
      elg_pkg::ST_OUT: begin
        out_valid = 1'b1;
        started_next = 1'b0;
        if (out_fire) state_next = elg_pkg::ST_IDLE;
      end
      default: state_next = elg_pkg::ST_IDLE;
    endcase
  end

  a_noacc: assert property (@(posedge clk) disable iff (rst)
    (state != elg_pkg::ST_IDLE) |-> !in_ready)
    else $error("ready while busy");
  a_ret: assert property (@(posedge clk) disable iff (rst)
    out_fire |=> (state == elg_pkg::ST_IDLE))
    else $error("no return to idle");
  a_go: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == elg_pkg::ST_REDUCE))
    else $error("accept did not start");
endmodule
